/* rtl/core/tbc_pkg.sv */
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared types and constants of the timer bank with calendar cascade.
// ----------------------------------------------------------------------------
package tbc_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int TICK_SLOT_DEF = 4;
	localparam int CNT_W = 16;

	localparam int FIRST_COUNTING = 4;
	localparam int CAL_SEC = 0;
	localparam int CAL_MIN = 1;
	localparam int CAL_HOUR = 2;
	localparam int CAL_DAY = 3;

	localparam logic [CNT_W-1:0] SEC_PER_MIN = 16'd60;
	localparam logic [CNT_W-1:0] MIN_PER_HOUR = 16'd60;
	localparam logic [CNT_W-1:0] HOUR_PER_DAY = 16'd24;
	localparam logic [CNT_W-1:0] TPS_RESET = 16'd1000;

	typedef enum logic [1:0] {
		SS_STOPPED = 2'd0,
		SS_RUNNING = 2'd1,
		SS_PAUSED  = 2'd2
	} slot_state_t;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_READ   = 3'd1,
		CMD_RESET  = 3'd2,
		CMD_START  = 3'd3,
		CMD_STOP   = 3'd4,
		CMD_PAUSE  = 3'd5,
		CMD_RESUME = 3'd6
	} cmd_t;

	typedef struct packed {
		slot_state_t      st;
		logic [CNT_W-1:0] cnt;
	} slot_word_t;

	typedef struct packed {
		logic             cin;
		logic             use_limit;
		logic [CNT_W-1:0] operand;
		logic [CNT_W-1:0] limit;
	} alu_req_t;

	typedef struct packed {
		logic             hit;
		logic [CNT_W-1:0] value;
	} alu_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_DONE
	} seq_state_t;

	typedef enum logic [2:0] {
		PH_LOOP,
		PH_TICKS,
		PH_SEC,
		PH_MIN,
		PH_HOUR,
		PH_DAY,
		PH_REPORT,
		PH_CMD
	} phase_t;

endpackage

/* rtl/core/timer_bank_with_calendar_unit.sv */
// ----------------------------------------------------------------------------
// timer_bank_with_calendar_unit
// Bank of 16-bit slot counters with tick walk and seconds/minutes/hours/days
// cascade, sharing one incrementer over a single-port slot store.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        input      in_valid/in_ready    command, timer_index
//  out       output     out_valid/out_ready  count_value, slot_state
//  cfg       APB        psel/penable/pready  paddr, pwdata, prdata
//
//  Tick: the slot walk visits slots 4 and up, then the cascade visits the tick
//  slot (skipped when TICK_SLOT lies outside the bank) and the calendar slots,
//  then report read and load, set by the one store port and one incrementer.
//  Other commands: read, modify-write, load; bad index: straight to the load.
//  Reset clears all slots to zero and stopped at once through valid bits.
//  A waiting result holds the sequencer in its last step; in_ready only in idle.
// ----------------------------------------------------------------------------
module timer_bank_with_calendar_unit
	import tbc_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	parameter int TICK_SLOT = TICK_SLOT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [3:0]  timer_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] count_value,
	output logic [1:0]  slot_state,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(NUM_SLOTS);

	logic [CNT_W-1:0] tps;
	logic             mem_rd_en;
	logic             mem_wr_en;
	logic [AW-1:0]    mem_addr;
	slot_word_t       mem_wr_data;
	slot_word_t       mem_rd_data;
	alu_req_t         alu_req;
	alu_rsp_t         alu_rsp;

	tbc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.tps     (tps)
	);

	tbc_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	tbc_slot_mem #(
		.NUM_SLOTS (NUM_SLOTS),
		.AW        (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_rd_en),
		.wr_en   (mem_wr_en),
		.addr    (mem_addr),
		.wr_data (mem_wr_data),
		.rd_data (mem_rd_data)
	);

	tbc_seq #(
		.NUM_SLOTS (NUM_SLOTS),
		.TICK_SLOT (TICK_SLOT),
		.AW        (AW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.timer_index (timer_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.count_value (count_value),
		.slot_state  (slot_state),
		.tps         (tps),
		.mem_rd_en   (mem_rd_en),
		.mem_wr_en   (mem_wr_en),
		.mem_addr    (mem_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_data (mem_rd_data),
		.alu_req     (alu_req),
		.alu_rsp     (alu_rsp)
	);

endmodule

/* rtl/core/tbc_cfg.sv */
// ----------------------------------------------------------------------------
// tbc_cfg
// APB register file holding ticks_per_second.
// ----------------------------------------------------------------------------
module tbc_cfg
	import tbc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic [CNT_W-1:0] tps
);

	localparam logic REG_TPS = 1'b0;

	logic [CNT_W-1:0] tps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_TPS) begin
			tps_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_TPS) ? {{(32-CNT_W){1'b0}}, tps_q} : 32'd0;
	assign pready = 1'b1;
	assign tps = tps_q;

endmodule

/* rtl/core/tbc_alu.sv */
// ----------------------------------------------------------------------------
// tbc_alu
// Shared increment and limit compare used for the tick walk and cascade visits.
// ----------------------------------------------------------------------------
module tbc_alu
	import tbc_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [CNT_W-1:0] sum;

	assign sum = req.operand + {{(CNT_W-1){1'b0}}, req.cin};
	assign rsp.hit = req.use_limit && (sum == req.limit);
	assign rsp.value = rsp.hit ? '0 : sum;

endmodule

/* rtl/core/tbc_slot_mem.sv */
// ----------------------------------------------------------------------------
// tbc_slot_mem
// Slot store: counter and run state per slot, with per-entry valid bits.
// ----------------------------------------------------------------------------
module tbc_slot_mem
	import tbc_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	parameter int AW = $clog2(NUM_SLOTS)
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rd_en,
	input  logic       wr_en,
	input  logic [AW-1:0] addr,
	input  slot_word_t wr_data,
	output slot_word_t rd_data
);

	slot_word_t             mem_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]   vld_q;
	slot_word_t             rd_q;
	logic                   rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

/* rtl/core/tbc_seq.sv */
// ----------------------------------------------------------------------------
// tbc_seq
// Command sequencer: walks the slots, runs the calendar cascade, reports.
// ----------------------------------------------------------------------------
module tbc_seq
	import tbc_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	parameter int TICK_SLOT = TICK_SLOT_DEF,
	parameter int AW = $clog2(NUM_SLOTS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       command,
	input  logic [3:0]       timer_index,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [CNT_W-1:0] count_value,
	output logic [1:0]       slot_state,
	input  logic [CNT_W-1:0] tps,
	output logic             mem_rd_en,
	output logic             mem_wr_en,
	output logic [AW-1:0]    mem_addr,
	output slot_word_t       mem_wr_data,
	input  slot_word_t       mem_rd_data,
	output alu_req_t         alu_req,
	input  alu_rsp_t         alu_rsp
);

	localparam bit TICK_IN = TICK_SLOT < NUM_SLOTS;

	seq_state_t       st_q, st_d;
	phase_t           ph_q, ph_d;
	logic [AW-1:0]    addr_q, addr_d;
	logic             carry_q, carry_d;
	cmd_t             cmd_q, cmd_d;
	logic [3:0]       idx_q, idx_d;
	slot_word_t       res_q, res_d;
	logic             load;
	logic             out_valid_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       state_q;
	logic             idx_ok_in;
	logic             idx_ok;
	slot_word_t       w;

	assign idx_ok_in = 32'(timer_index) < 32'(NUM_SLOTS);
	assign idx_ok = 32'(idx_q) < 32'(NUM_SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ph_q <= PH_LOOP;
			addr_q <= '0;
			carry_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			ph_q <= ph_d;
			addr_q <= addr_d;
			carry_q <= carry_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		idx_q <= idx_d;
		res_q <= res_d;
		if (load) begin
			count_q <= res_q.cnt;
			state_q <= res_q.st;
		end
	end

	always_comb begin
		st_d = st_q;
		ph_d = ph_q;
		addr_d = addr_q;
		carry_d = carry_q;
		cmd_d = cmd_q;
		idx_d = idx_q;
		res_d = res_q;
		load = 1'b0;
		mem_rd_en = 1'b0;
		mem_wr_en = 1'b0;
		mem_wr_data = mem_rd_data;
		alu_req = '0;
		alu_req.operand = mem_rd_data.cnt;
		w = mem_rd_data;
		unique case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd_d = cmd_t'(command);
					idx_d = timer_index;
					if (cmd_t'(command) == CMD_TICK) begin
						ph_d = PH_LOOP;
						addr_d = AW'(FIRST_COUNTING);
						st_d = ST_READ;
					end else if (idx_ok_in) begin
						ph_d = PH_CMD;
						addr_d = AW'(timer_index);
						st_d = ST_READ;
					end else begin
						res_d = '0;
						st_d = ST_DONE;
					end
				end
			end
			ST_READ: begin
				mem_rd_en = 1'b1;
				st_d = ST_EXEC;
			end
			ST_EXEC: begin
				st_d = ST_READ;
				unique case (ph_q)
					PH_LOOP: begin
						alu_req.cin = mem_rd_data.st == SS_RUNNING;
						mem_wr_en = alu_req.cin;
						mem_wr_data.cnt = alu_rsp.value;
						carry_d = 1'b0;
						if (addr_q == AW'(NUM_SLOTS - 1)) begin
							if (TICK_IN) begin
								ph_d = PH_TICKS;
								addr_d = AW'(TICK_SLOT);
							end else begin
								ph_d = PH_SEC;
								addr_d = AW'(CAL_SEC);
							end
						end else begin
							addr_d = addr_q + 1'b1;
						end
					end
					PH_TICKS: begin
						alu_req.use_limit = 1'b1;
						alu_req.limit = tps;
						mem_wr_en = alu_rsp.hit;
						mem_wr_data.cnt = alu_rsp.value;
						carry_d = alu_rsp.hit;
						ph_d = PH_SEC;
						addr_d = AW'(CAL_SEC);
					end
					PH_SEC, PH_MIN, PH_HOUR: begin
						alu_req.cin = carry_q;
						alu_req.use_limit = 1'b1;
						if (ph_q == PH_SEC) begin
							alu_req.limit = SEC_PER_MIN;
							ph_d = PH_MIN;
							addr_d = AW'(CAL_MIN);
						end else if (ph_q == PH_MIN) begin
							alu_req.limit = MIN_PER_HOUR;
							ph_d = PH_HOUR;
							addr_d = AW'(CAL_HOUR);
						end else begin
							alu_req.limit = HOUR_PER_DAY;
							ph_d = PH_DAY;
							addr_d = AW'(CAL_DAY);
						end
						mem_wr_en = carry_q || alu_rsp.hit;
						mem_wr_data.cnt = alu_rsp.value;
						carry_d = alu_rsp.hit;
					end
					PH_DAY: begin
						alu_req.cin = carry_q;
						mem_wr_en = carry_q;
						mem_wr_data.cnt = alu_rsp.value;
						carry_d = 1'b0;
						if (idx_ok) begin
							ph_d = PH_REPORT;
							addr_d = AW'(idx_q);
						end else begin
							res_d = '0;
							st_d = ST_DONE;
						end
					end
					PH_REPORT: begin
						res_d = mem_rd_data;
						st_d = ST_DONE;
					end
					PH_CMD: begin
						unique case (cmd_q)
							CMD_RESET: begin
								w.cnt = '0;
							end
							CMD_START: begin
								if (mem_rd_data.st == SS_STOPPED) begin
									w.cnt = '0;
									w.st = SS_RUNNING;
								end
							end
							CMD_STOP: begin
								w.st = SS_STOPPED;
							end
							CMD_PAUSE: begin
								if (mem_rd_data.st == SS_RUNNING) begin
									w.st = SS_PAUSED;
								end
							end
							CMD_RESUME: begin
								if (mem_rd_data.st == SS_PAUSED) begin
									w.st = SS_RUNNING;
								end
							end
							default: begin
							end
						endcase
						mem_wr_en = 1'b1;
						mem_wr_data = w;
						res_d = w;
						st_d = ST_DONE;
					end
					default: begin
						st_d = ST_IDLE;
					end
				endcase
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load = 1'b1;
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	assign in_ready = st_q == ST_IDLE;
	assign mem_addr = addr_q;
	assign out_valid = out_valid_q;
	assign count_value = count_q;
	assign slot_state = state_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> st_q != ST_IDLE)
		else $error("sequencer stayed idle after accepting a word");

	a_write_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> st_q == ST_EXEC && !mem_rd_en)
		else $error("slot write outside execute step");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q) == ST_DONE)
		else $error("result loaded outside done step");

	a_loop_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_EXEC && ph_q == PH_LOOP |-> 32'(addr_q) >= FIRST_COUNTING)
		else $error("tick walk visited a calendar slot");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for timer_bank_with_calendar_unit. Commands go in over
// the valid/ready channel. A bank model inside the bench predicts the report
// of each accepted word, and the report channel is checked against it field by
// field. Both channels idle at random. ticks_per_second is reprogrammed over
// APB between phases and read back. The phases are a directed walk over every
// command, a long tick run that rolls seconds into minutes twice, and random
// slot lifecycles mixed with noise.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tbc_pkg::*;

	localparam logic [2:0] CMD_NOP = 3'd7;
	localparam logic [2:0] REG_TPS = 3'd0;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int SETTLE_CYCLES = 64;
	localparam int IDLE_PCT = 35;
	localparam int CAL_TICKS = 125;
	localparam int PHASE_WORDS = 62;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  command;
	logic [3:0]  timer_index;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] count_value;
	logic [1:0]  slot_state;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	logic [CNT_W-1:0] bank_cnt [NUM_SLOTS_DEF];
	slot_state_t      bank_st [NUM_SLOTS_DEF];
	logic [CNT_W-1:0] tps_val;
	slot_word_t       pending_reports [$];

	int  sent_cnt;
	int  done_cnt;
	int  err_cnt;
	int  cycle_cnt;
	bit  idle_on;

	timer_bank_with_calendar_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.timer_index (timer_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.count_value (count_value),
		.slot_state  (slot_state),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d reports outstanding", $time, sent_cnt - done_cnt);
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
	end

	function automatic void clear_bank();
		for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
			bank_cnt[i] = '0;
			bank_st[i] = SS_STOPPED;
		end
		tps_val = TPS_RESET;
	endfunction

	function automatic slot_word_t step_bank(input logic [2:0] code, input logic [3:0] idx);
		slot_word_t rep;
		case (code)
			CMD_TICK: begin
				for (int i = FIRST_COUNTING; i < NUM_SLOTS_DEF; i++)
					if (bank_st[i] == SS_RUNNING)
						bank_cnt[i] = bank_cnt[i] + 1'b1;
				if (TICK_SLOT_DEF < NUM_SLOTS_DEF && bank_cnt[TICK_SLOT_DEF] == tps_val) begin
					bank_cnt[CAL_SEC] = bank_cnt[CAL_SEC] + 1'b1;
					bank_cnt[TICK_SLOT_DEF] = '0;
				end
				if (bank_cnt[CAL_SEC] == SEC_PER_MIN) begin
					bank_cnt[CAL_MIN] = bank_cnt[CAL_MIN] + 1'b1;
					bank_cnt[CAL_SEC] = '0;
				end
				if (bank_cnt[CAL_MIN] == MIN_PER_HOUR) begin
					bank_cnt[CAL_HOUR] = bank_cnt[CAL_HOUR] + 1'b1;
					bank_cnt[CAL_MIN] = '0;
				end
				if (bank_cnt[CAL_HOUR] == HOUR_PER_DAY) begin
					bank_cnt[CAL_DAY] = bank_cnt[CAL_DAY] + 1'b1;
					bank_cnt[CAL_HOUR] = '0;
				end
			end
			CMD_RESET: bank_cnt[idx] = '0;
			CMD_START: begin
				if (bank_st[idx] == SS_STOPPED) begin
					bank_cnt[idx] = '0;
					bank_st[idx] = SS_RUNNING;
				end
			end
			CMD_STOP: bank_st[idx] = SS_STOPPED;
			CMD_PAUSE: begin
				if (bank_st[idx] == SS_RUNNING)
					bank_st[idx] = SS_PAUSED;
			end
			CMD_RESUME: begin
				if (bank_st[idx] == SS_PAUSED)
					bank_st[idx] = SS_RUNNING;
			end
			default: ;
		endcase
		rep.cnt = bank_cnt[idx];
		rep.st = bank_st[idx];
		return rep;
	endfunction

	always @(posedge clk) begin
		slot_word_t want;
		if (arst_n && in_valid && in_ready)
			pending_reports.push_back(step_bank(command, timer_index));
		if (arst_n && out_valid && out_ready) begin
			done_cnt++;
			if (pending_reports.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected word, count_value=%0d slot_state=%0d",
					$time, count_value, slot_state);
			end else begin
				want = pending_reports.pop_front();
				if (count_value !== want.cnt) begin
					err_cnt++;
					$display("%0t: count_value expected %0d actual %0d",
						$time, want.cnt, count_value);
				end
				if (slot_state !== want.st) begin
					err_cnt++;
					$display("%0t: slot_state expected %0d actual %0d",
						$time, want.st, slot_state);
				end
			end
		end
	end

	task automatic send_word(input logic [2:0] code, input logic [3:0] idx);
		if (idle_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		in_valid <= 1'b1;
		command <= code;
		timer_index <= idx;
		sent_cnt++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_reports();
		in_valid <= 1'b0;
		while (done_cnt != sent_cnt) @(posedge clk);
	endtask

	task automatic write_tps(input logic [15:0] val);
		logic [31:0] rd;
		drain_reports();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_TPS;
		pwdata <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tps_val = val;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd[15:0] !== val) begin
			err_cnt++;
			$display("%0t: ticks_per_second readback expected %0d actual %0d",
				$time, val, rd[15:0]);
		end
	endtask

	function automatic logic [3:0] pick_slot();
		if ($urandom_range(99) < 50)
			return 4'($urandom_range(0, 5));
		return 4'($urandom_range(0, 15));
	endfunction

	task automatic test_directed_commands();
		send_word(CMD_READ, 4'd0);
		send_word(CMD_READ, 4'd15);
		send_word(CMD_START, 4'd4);
		send_word(CMD_START, 4'd15);
		send_word(CMD_TICK, 4'd4);
		send_word(CMD_START, 4'd4);
		send_word(CMD_PAUSE, 4'd4);
		send_word(CMD_TICK, 4'd4);
		send_word(CMD_PAUSE, 4'd4);
		send_word(CMD_RESUME, 4'd4);
		send_word(CMD_RESUME, 4'd4);
		send_word(CMD_TICK, 4'd15);
		send_word(CMD_RESET, 4'd15);
		send_word(CMD_STOP, 4'd15);
		send_word(CMD_TICK, 4'd15);
		send_word(CMD_NOP, 4'd4);
		send_word(CMD_START, 4'd0);
		send_word(CMD_TICK, 4'd0);
		send_word(CMD_PAUSE, 4'd0);
		send_word(CMD_RESUME, 4'd3);
		send_word(CMD_STOP, 4'd0);
		send_word(CMD_START, 4'd10);
		send_word(CMD_TICK, 4'd10);
		send_word(CMD_NOP, 4'd11);
	endtask

	task automatic test_calendar_cascade();
		write_tps(16'd0);
		idle_on = 1'b0;
		send_word(CMD_RESET, 4'd0);
		send_word(CMD_RESET, 4'd1);
		send_word(CMD_STOP, 4'd4);
		send_word(CMD_RESET, 4'd4);
		repeat (CAL_TICKS) send_word(CMD_TICK, 4'($urandom_range(0, 4)));
		send_word(CMD_READ, 4'd2);
		drain_reports();
		idle_on = 1'b1;
	endtask

	task automatic run_slot_burst();
		logic [3:0] s;
		s = pick_slot();
		send_word(CMD_START, s);
		repeat ($urandom_range(1, 6)) send_word(CMD_TICK, pick_slot());
		send_word(CMD_PAUSE, s);
		repeat ($urandom_range(0, 2)) send_word(CMD_TICK, pick_slot());
		send_word(CMD_RESUME, s);
		repeat ($urandom_range(0, 4)) send_word(CMD_TICK, pick_slot());
		if ($urandom_range(1))
			send_word(CMD_STOP, s);
		else
			send_word(CMD_RESET, s);
		send_word(CMD_READ, s);
	endtask

	task automatic test_random_traffic();
		int goal;
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: write_tps(16'd1);
				1: write_tps(16'd0);
				2: write_tps(16'd3);
				3: write_tps(16'($urandom_range(2, 12)));
				4: write_tps(16'hFFFF);
				default: write_tps(16'($urandom));
			endcase
			goal = sent_cnt + PHASE_WORDS;
			while (sent_cnt < goal) begin
				if ($urandom_range(99) < 70)
					run_slot_burst();
				else
					send_word(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_READ;
		timer_index <= '0;
		out_ready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		sent_cnt = 0;
		done_cnt = 0;
		err_cnt = 0;
		cycle_cnt = 0;
		idle_on = 1'b1;
		clear_bank();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_commands();
		test_calendar_cascade();
		test_random_traffic();

		drain_reports();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
